// ===== rtl/core/icymd_pkg.sv =====
// Types and constants shared by the metadata deframer modules.
package icymd_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 10;
    localparam int TLEN_W      = 10;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 16;
    localparam int REM_W       = 12;
    localparam int CFG_W       = 16;
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 2;

    localparam logic [COUNT_W-1:0] INTERVAL_RESET = 16'd8192;
    localparam logic [BYTE_W-1:0]  CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0]  CHAR_QUOTE = 8'h27;
    localparam logic [BYTE_W-1:0]  CHAR_SEMI  = 8'h3B;
    localparam int                 BLOCK_SHIFT = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_AUDIO = 2'd0,
        KIND_TITLE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_AUDIO  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_META   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SC_SEEK  = 2'd0,
        SC_TITLE = 2'd1,
        SC_QUOTE = 2'd2,
        SC_DONE  = 2'd3
    } scan_t;

    typedef enum logic [0:0] {
        CFG_ENABLE   = 1'b0,
        CFG_INTERVAL = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic [TLEN_W-1:0]  length;
    } result_t;

endpackage

// ===== rtl/core/icymd_title_ram.sv =====
// Title character memory: one write port, one registered read port.
module icymd_title_ram
    import icymd_pkg::*;
#(
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              wen,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              ren,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/icymd_result_queue.sv =====
// Three-word result queue between the core pipeline and the output channel.
module icymd_result_queue
    import icymd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           push_word,
    input  logic              pop,
    output logic [QCNT_W-1:0] count,
    output result_t           head
);

    result_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign count = count_reg;
    assign head  = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/icy_metadata_deframer.sv =====
// Stream metadata deframer top level: framing, title scan, banked title store.
//
// Takes one word per cycle on the item channel while item_stall is low, stream bytes
// and title reads alike, and returns each result through the stage register and a
// three-word output queue; item_stall rises when that queue and the stage feeding it
// hold three words between them.
// The title lives in two byte memories split by address parity, each holding both
// banks, so the two characters a quote escape can append in one word are written
// in the same cycle. The comparison against the stored title reads the active bank
// in the same cycle and resolves in the next cycle, which is in time for the closing
// quote-semicolon. Configuration writes restart framing and keep the stored title.
module icy_metadata_deframer
    import icymd_pkg::*;
#(
    parameter int TITLE_MAX = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              req_type,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [IDX_W-1:0]  read_index,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [KIND_W-1:0] result_kind,
    output logic [BYTE_W-1:0] data_out,
    output logic [TLEN_W-1:0] title_length
);

    localparam int LEN_W  = $clog2(TITLE_MAX);
    localparam int RAM_AW = LEN_W;
    localparam int CW     = (LEN_W > IDX_W) ? LEN_W : IDX_W;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TITLE_MAX - 1);

    logic                enable_reg, enable_next;
    logic [COUNT_W-1:0]  interval_reg, interval_next;
    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  audio_count_reg, audio_count_next;
    logic [REM_W-1:0]    meta_rem_reg, meta_rem_next;
    scan_t               scan_reg, scan_next;
    logic                active_bank_reg, active_bank_next;
    logic [LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]    new_len_reg, new_len_next;
    logic                mismatch_reg, mismatch_next;

    logic                s1_valid_reg, s1_valid_next;
    kind_t               s1_kind_reg, s1_kind_next;
    logic [BYTE_W-1:0]   s1_byte_reg, s1_byte_next;
    logic                s1_from_mem_reg, s1_from_mem_next;
    logic                s1_odd_reg, s1_odd_next;
    logic [TLEN_W-1:0]   s1_len_reg, s1_len_next;

    logic [1:0]          cmp_valid_reg, cmp_valid_next;
    logic [BYTE_W-1:0]   cmp_char_reg [2];
    logic [BYTE_W-1:0]   cmp_char_next [2];

    logic                wen   [2];
    logic [RAM_AW-1:0]   waddr [2];
    logic [BYTE_W-1:0]   wdata [2];
    logic                ren   [2];
    logic [RAM_AW-1:0]   raddr [2];
    logic [BYTE_W-1:0]   rdata [2];

    logic                item_acc;
    logic                fold;
    logic [CW-1:0]       idx_ext;
    logic [CW-1:0]       cur_ext;
    logic [QCNT_W-1:0]   q_count;
    logic [QCNT_W:0]     occupancy;
    result_t             push_word;
    result_t             head;

    assign occupancy  = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg);
    assign item_stall = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign item_acc   = item_valid && !item_stall;
    assign idx_ext    = CW'(read_index);
    assign cur_ext    = CW'(cur_len_reg);
    assign fold       = (cmp_valid_reg[0] && (rdata[0] != cmp_char_reg[0])) ||
                        (cmp_valid_reg[1] && (rdata[1] != cmp_char_reg[1]));

    always_comb
    begin
        logic             app_v [2];
        logic [BYTE_W-1:0] app_c [2];
        logic [LEN_W-1:0] nl_run;
        logic [REM_W-1:0] rem_dec;
        logic [COUNT_W-1:0] cnt_inc;
        logic             p;

        enable_next      = enable_reg;
        interval_next    = interval_reg;
        phase_next       = phase_reg;
        audio_count_next = audio_count_reg;
        meta_rem_next    = meta_rem_reg;
        scan_next        = scan_reg;
        active_bank_next = active_bank_reg;
        cur_len_next     = cur_len_reg;
        new_len_next     = new_len_reg;
        mismatch_next    = mismatch_reg || fold;

        s1_valid_next    = 1'b0;
        s1_kind_next     = s1_kind_reg;
        s1_byte_next     = s1_byte_reg;
        s1_from_mem_next = 1'b0;
        s1_odd_next      = s1_odd_reg;
        s1_len_next      = s1_len_reg;

        cmp_valid_next   = '0;
        app_v            = '{1'b0, 1'b0};
        app_c            = '{CHAR_NUL, CHAR_NUL};
        nl_run           = new_len_reg;
        rem_dec          = '0;
        cnt_inc          = audio_count_reg + 1'b1;
        p                = 1'b0;

        for (int m = 0; m < 2; m++)
        begin
            cmp_char_next[m] = cmp_char_reg[m];
            wen[m]   = 1'b0;
            waddr[m] = '0;
            wdata[m] = '0;
            ren[m]   = 1'b0;
            raddr[m] = '0;
        end

        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ENABLE:   enable_next   = cfg_data[0];
                CFG_INTERVAL: interval_next = cfg_data;
                default:      enable_next   = enable_reg;
            endcase
            phase_next       = PH_AUDIO;
            audio_count_next = '0;
            meta_rem_next    = '0;
            scan_next        = SC_SEEK;
        end
        else if (item_acc)
        begin
            if (req_type)
            begin
                s1_valid_next = 1'b1;
                s1_kind_next  = KIND_READ;
                s1_len_next   = TLEN_W'(cur_len_reg);
                s1_byte_next  = CHAR_NUL;
                if (idx_ext < cur_ext)
                begin
                    s1_from_mem_next = 1'b1;
                    s1_odd_next      = idx_ext[0];
                    ren[idx_ext[0]]  = 1'b1;
                    raddr[idx_ext[0]] = {active_bank_reg, idx_ext[LEN_W-1:1]};
                end
            end
            else if (!enable_reg || phase_reg == PH_AUDIO)
            begin
                s1_valid_next = 1'b1;
                s1_kind_next  = KIND_AUDIO;
                s1_byte_next  = data_byte;
                s1_len_next   = TLEN_W'(cur_len_reg);
                if (enable_reg)
                begin
                    if (cnt_inc == interval_reg)
                    begin
                        audio_count_next = '0;
                        phase_next       = PH_LENGTH;
                    end
                    else
                    begin
                        audio_count_next = cnt_inc;
                    end
                end
            end
            else if (phase_reg == PH_LENGTH)
            begin
                meta_rem_next = {data_byte, {BLOCK_SHIFT{1'b0}}};
                scan_next     = SC_SEEK;
                phase_next    = (data_byte == CHAR_NUL) ? PH_AUDIO : PH_META;
            end
            else
            begin
                case (scan_reg)
                    SC_SEEK:
                    begin
                        if (data_byte == CHAR_NUL)
                        begin
                            scan_next = SC_DONE;
                        end
                        else if (data_byte == CHAR_QUOTE)
                        begin
                            new_len_next  = '0;
                            mismatch_next = 1'b0;
                            scan_next     = SC_TITLE;
                        end
                    end
                    SC_TITLE:
                    begin
                        if (data_byte == CHAR_NUL)
                        begin
                            scan_next = SC_DONE;
                        end
                        else if (data_byte == CHAR_QUOTE)
                        begin
                            scan_next = SC_QUOTE;
                        end
                        else
                        begin
                            app_v[0] = 1'b1;
                            app_c[0] = data_byte;
                        end
                    end
                    SC_QUOTE:
                    begin
                        if (data_byte == CHAR_NUL)
                        begin
                            scan_next = SC_DONE;
                        end
                        else if (data_byte == CHAR_SEMI)
                        begin
                            scan_next = SC_DONE;
                            if (mismatch_reg || fold || (new_len_reg != cur_len_reg))
                            begin
                                active_bank_next = ~active_bank_reg;
                                cur_len_next     = new_len_reg;
                                s1_valid_next    = 1'b1;
                                s1_kind_next     = KIND_TITLE;
                                s1_byte_next     = CHAR_NUL;
                                s1_len_next      = TLEN_W'(new_len_reg);
                            end
                        end
                        else
                        begin
                            app_v[0] = 1'b1;
                            app_c[0] = CHAR_QUOTE;
                            if (data_byte != CHAR_QUOTE)
                            begin
                                app_v[1]  = 1'b1;
                                app_c[1]  = data_byte;
                                scan_next = SC_TITLE;
                            end
                        end
                    end
                    default:
                    begin
                        scan_next = scan_reg;
                    end
                endcase

                // consecutive appends land in opposite-parity memories
                for (int k = 0; k < 2; k++)
                begin
                    if (app_v[k] && (nl_run < LEN_LIMIT))
                    begin
                        p        = nl_run[0];
                        wen[p]   = 1'b1;
                        waddr[p] = {~active_bank_reg, nl_run[LEN_W-1:1]};
                        wdata[p] = app_c[k];
                        if (nl_run >= cur_len_reg)
                        begin
                            mismatch_next = 1'b1;
                        end
                        else
                        begin
                            ren[p]            = 1'b1;
                            raddr[p]          = {active_bank_reg, nl_run[LEN_W-1:1]};
                            cmp_valid_next[p] = 1'b1;
                            cmp_char_next[p]  = app_c[k];
                        end
                        nl_run = nl_run + 1'b1;
                    end
                end
                if (app_v[0])
                begin
                    new_len_next = nl_run;
                end

                rem_dec = meta_rem_reg - REM_W'(meta_rem_reg != '0);
                meta_rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_AUDIO;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            interval_reg    <= INTERVAL_RESET;
            phase_reg       <= PH_AUDIO;
            audio_count_reg <= '0;
            meta_rem_reg    <= '0;
            scan_reg        <= SC_SEEK;
            active_bank_reg <= 1'b0;
            cur_len_reg     <= '0;
            new_len_reg     <= '0;
            mismatch_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_from_mem_reg <= 1'b0;
            cmp_valid_reg   <= '0;
        end
        else
        begin
            enable_reg      <= enable_next;
            interval_reg    <= interval_next;
            phase_reg       <= phase_next;
            audio_count_reg <= audio_count_next;
            meta_rem_reg    <= meta_rem_next;
            scan_reg        <= scan_next;
            active_bank_reg <= active_bank_next;
            cur_len_reg     <= cur_len_next;
            new_len_reg     <= new_len_next;
            mismatch_reg    <= mismatch_next;
            s1_valid_reg    <= s1_valid_next;
            s1_from_mem_reg <= s1_from_mem_next;
            cmp_valid_reg   <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg     <= s1_kind_next;
        s1_byte_reg     <= s1_byte_next;
        s1_odd_reg      <= s1_odd_next;
        s1_len_reg      <= s1_len_next;
        cmp_char_reg[0] <= cmp_char_next[0];
        cmp_char_reg[1] <= cmp_char_next[1];
    end

    for (genvar m = 0; m < 2; m++)
    begin : g_ram
        icymd_title_ram #(
            .ADDR_W (RAM_AW)
        ) u_ram (
            .clk   (clk),
            .wen   (wen[m]),
            .waddr (waddr[m]),
            .wdata (wdata[m]),
            .ren   (ren[m]),
            .raddr (raddr[m]),
            .rdata (rdata[m])
        );
    end

    assign push_word.kind   = s1_kind_reg;
    assign push_word.data   = s1_from_mem_reg ? rdata[s1_odd_reg] : s1_byte_reg;
    assign push_word.length = s1_len_reg;

    icymd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_word (push_word),
        .pop       (result_valid && !result_stall),
        .count     (q_count),
        .head      (head)
    );

    assign result_valid = q_count != '0;
    assign result_kind  = head.kind;
    assign data_out     = head.data;
    assign title_length = head.length;

    a_wr_spare_even: assert property (@(posedge clk) disable iff (!rst_n)
        wen[0] |-> (waddr[0][RAM_AW-1] != active_bank_reg))
        else $error("even title write hits the active bank");

    a_wr_spare_odd: assert property (@(posedge clk) disable iff (!rst_n)
        wen[1] |-> (waddr[1][RAM_AW-1] != active_bank_reg))
        else $error("odd title write hits the active bank");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_len_reg <= LEN_LIMIT)
        else $error("stored title length beyond limit");

    a_swap_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_kind_reg == KIND_TITLE) |->
            (active_bank_reg != $past(active_bank_reg)))
        else $error("title change reported without bank swap");

    a_cmp_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmp_valid_reg != '0) |-> $past(item_acc))
        else $error("title compare pending without an accepted word");

endmodule

// ===== tb/icy_metadata_deframer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the metadata deframer: framing, title scan, title store reads.
module icy_metadata_deframer_tb;
    import icymd_pkg::*;

    localparam int TITLE_MAX    = 1024;
    localparam int POOL_N       = 4;
    localparam int POOL_CHARS   = 32;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic              rq;
        logic [BYTE_W-1:0] b;
        logic [IDX_W-1:0]  ix;
    } stream_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wen = 1'b0;
    logic [0:0]        cfg_index = CFG_ENABLE;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic              req_type = 1'b0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [IDX_W-1:0]  read_index = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] data_out;
    logic [TLEN_W-1:0] title_length;

    // predicted block state
    bit                meta_en = 1'b0;
    logic [COUNT_W-1:0] interval = INTERVAL_RESET;
    phase_t            ph = PH_AUDIO;
    scan_t             sc = SC_SEEK;
    logic [COUNT_W-1:0] aud_cnt = '0;
    int                meta_rem = 0;
    logic [BYTE_W-1:0] title_store [0:2*TITLE_MAX-1];
    int                act_bank = 0;
    int                cur_len = 0;
    int                new_len = 0;
    bit                title_diff = 1'b0;

    result_t           expected_results [$];
    stream_word_t      pending_words [$];
    logic [BYTE_W-1:0] blk_q [$];
    logic [BYTE_W-1:0] pool_chars [POOL_N][POOL_CHARS];
    int                pool_len [POOL_N];

    bit  word_taken = 1'b0;
    bit  word_held = 1'b0;
    bit  idle_ok = 1'b0;
    bit  mix_reads = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  cycle_count = 0;
    int  errors = 0;
    int  results_checked = 0;
    int  title_changes = 0;
    int  stim_words = 0;
    int  config_writes = 0;
    stream_word_t w;
    result_t want;

    icy_metadata_deframer #(
        .TITLE_MAX (TITLE_MAX)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .req_type     (req_type),
        .data_byte    (data_byte),
        .read_index   (read_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .data_out     (data_out),
        .title_length (title_length)
    );

    always #2 clk = ~clk;

    function automatic void append_title_char(input logic [BYTE_W-1:0] c);
        int spare;
        spare = 1 - act_bank;
        if (new_len < TITLE_MAX - 1)
        begin
            title_store[spare*TITLE_MAX + new_len] = c;
            if (new_len >= cur_len || title_store[act_bank*TITLE_MAX + new_len] != c)
                title_diff = 1'b1;
            new_len++;
        end
    endfunction

    function automatic bit scan_meta_byte(input logic [BYTE_W-1:0] c);
        bit changed;
        changed = 1'b0;
        case (sc)
            SC_SEEK:
                if (c == CHAR_NUL)
                    sc = SC_DONE;
                else if (c == CHAR_QUOTE)
                begin
                    new_len = 0;
                    title_diff = 1'b0;
                    sc = SC_TITLE;
                end
            SC_TITLE:
                if (c == CHAR_NUL)
                    sc = SC_DONE;
                else if (c == CHAR_QUOTE)
                    sc = SC_QUOTE;
                else
                    append_title_char(c);
            SC_QUOTE:
                if (c == CHAR_NUL)
                    sc = SC_DONE;
                else if (c == CHAR_SEMI)
                begin
                    sc = SC_DONE;
                    if (title_diff || new_len != cur_len)
                    begin
                        act_bank = 1 - act_bank;
                        cur_len = new_len;
                        changed = 1'b1;
                    end
                end
                else
                begin
                    append_title_char(CHAR_QUOTE);
                    if (c != CHAR_QUOTE)
                    begin
                        append_title_char(c);
                        sc = SC_TITLE;
                    end
                end
            default: ;
        endcase
        return changed;
    endfunction

    task automatic predict_word(input stream_word_t sw);
        result_t r;
        r.kind = KIND_AUDIO;
        r.data = sw.b;
        r.length = TLEN_W'(cur_len);
        if (sw.rq)
        begin
            r.kind = KIND_READ;
            r.data = (sw.ix < cur_len) ? title_store[act_bank*TITLE_MAX + sw.ix] : CHAR_NUL;
            expected_results.push_back(r);
        end
        else if (!meta_en || ph == PH_AUDIO)
        begin
            if (meta_en)
            begin
                aud_cnt = aud_cnt + 1'b1;
                if (aud_cnt == interval)
                begin
                    aud_cnt = '0;
                    ph = PH_LENGTH;
                end
            end
            expected_results.push_back(r);
        end
        else if (ph == PH_LENGTH)
        begin
            meta_rem = int'(sw.b) << BLOCK_SHIFT;
            sc = SC_SEEK;
            ph = (meta_rem == 0) ? PH_AUDIO : PH_META;
        end
        else
        begin
            if (scan_meta_byte(sw.b))
            begin
                r.kind = KIND_TITLE;
                r.data = '0;
                r.length = TLEN_W'(cur_len);
                expected_results.push_back(r);
            end
            if (meta_rem > 0)
                meta_rem--;
            if (meta_rem == 0)
                ph = PH_AUDIO;
        end
    endtask

    // results, config mirror and acceptance, all sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d data %0h length %0d",
                           result_kind, data_out, title_length);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.kind == KIND_TITLE)
                        title_changes++;
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind mismatch: expected %0d, got %0d",
                               want.kind, result_kind);
                        errors++;
                    end
                    if (data_out !== want.data)
                    begin
                        $error("data_out mismatch: expected %0h, got %0h", want.data, data_out);
                        errors++;
                    end
                    if (title_length !== want.length)
                    begin
                        $error("title_length mismatch: expected %0d, got %0d",
                               want.length, title_length);
                        errors++;
                    end
                end
            end
            if (cfg_wen)
            begin
                if (cfg_index == CFG_ENABLE)
                    meta_en = cfg_data[0];
                else
                    interval = cfg_data;
                ph = PH_AUDIO;
                aud_cnt = '0;
                meta_rem = 0;
                sc = SC_SEEK;
            end
            if (item_valid && !item_stall)
                predict_word('{rq: req_type, b: data_byte, ix: read_index});
        end
        word_taken = rst_n && item_valid && !item_stall;
    end

    // word driver
    always @(negedge clk)
    begin
        if (word_held && word_taken)
            word_held = 1'b0;
        if (!word_held)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (idle_ok && $urandom_range(0, 15) == 0)
                gap_left = $urandom_range(0, 13);
            else if (pending_words.size() != 0)
            begin
                w = pending_words.pop_front();
                req_type <= w.rq;
                data_byte <= w.b;
                read_index <= w.ix;
                word_held = 1'b1;
            end
            item_valid <= word_held;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_ok && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 14);
        result_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_word(input logic rq, input logic [BYTE_W-1:0] b,
                             input logic [IDX_W-1:0] ix);
        pending_words.push_back('{rq: rq, b: b, ix: ix});
        stim_words++;
    endtask

    task automatic push_read();
        int r;
        logic [IDX_W-1:0] ix;
        r = $urandom_range(0, 9);
        if (r < 6)
            ix = IDX_W'($urandom_range(0, 30));
        else if (r < 9)
            ix = IDX_W'($urandom);
        else
            ix = '1;
        push_word(1'b1, BYTE_W'($urandom), ix);
    endtask

    task automatic push_stream(input logic [BYTE_W-1:0] b);
        if (mix_reads && $urandom_range(0, 11) == 0)
            push_read();
        push_word(1'b0, b, IDX_W'($urandom));
    endtask

    task automatic push_audio(input int n);
        repeat (n)
            push_stream(BYTE_W'($urandom));
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            blk_q.push_back(s[i]);
    endtask

    task automatic add_title(input int p, input int n);
        blk_q.push_back(CHAR_QUOTE);
        for (int i = 0; i < n; i++)
            blk_q.push_back(pool_chars[p][i]);
        blk_q.push_back(CHAR_QUOTE);
        blk_q.push_back(CHAR_SEMI);
    endtask

    // length word, then blocks*16 metadata words taken from blk_q and padded
    task automatic send_block(input int blocks);
        bit pad_rand;
        pad_rand = ($urandom_range(0, 3) == 0);
        push_stream(BYTE_W'(blocks));
        for (int i = 0; i < blocks * 16; i++)
        begin
            if (i < blk_q.size())
                push_stream(blk_q[i]);
            else if (pad_rand)
                push_stream(BYTE_W'($urandom));
            else
                push_stream(CHAR_NUL);
        end
        blk_q.delete();
    endtask

    function automatic logic [BYTE_W-1:0] rand_title_char();
        if ($urandom_range(0, 7) == 0)
            return BYTE_W'($urandom_range(1, 255));
        return BYTE_W'($urandom_range(32, 126));
    endfunction

    task automatic send_random_block();
        int k, p, n, blocks;
        k = $urandom_range(0, 15);
        p = $urandom_range(0, POOL_N - 1);
        if ($urandom_range(0, 3) == 0 && pool_len[p] > 0)
            pool_chars[p][$urandom_range(0, pool_len[p] - 1)] = rand_title_char();
        n = pool_len[p];
        if ($urandom_range(0, 7) == 0 && n > 0)
            n = $urandom_range(0, n - 1);
        add_text("StreamTitle=");
        add_title(p, n);
        case (k)
            11:
            begin
                blk_q.insert($urandom_range(0, 12), CHAR_NUL);
                blocks = (blk_q.size() + 15) / 16;
            end
            12:
            begin
                blk_q.insert($urandom_range(13, 13 + n), CHAR_NUL);
                blocks = (blk_q.size() + 15) / 16;
            end
            13: blocks = blk_q.size() / 16;
            14:
            begin
                blk_q.delete();
                repeat ($urandom_range(1, 48))
                    blk_q.push_back(BYTE_W'($urandom));
                blocks = (blk_q.size() + 15) / 16;
            end
            15: blocks = 0;
            default:
            begin
                add_text("StreamUrl='';");
                blocks = (blk_q.size() + 15) / 16 + $urandom_range(0, 1);
            end
        endcase
        send_block(blocks);
    endtask

    task automatic send_frames(input int ival, input int budget);
        int stop;
        stop = stim_words + budget;
        while (stim_words < stop)
        begin
            push_audio(ival);
            send_random_block();
        end
        // sometimes leave framing mid-interval or mid-block for the next write
        case ($urandom_range(0, 2))
            1: push_audio($urandom_range(1, ival));
            2:
            begin
                push_audio(ival);
                push_stream(BYTE_W'(3));
                push_audio(7);
            end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || word_held || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input bit en, input logic [CFG_W-1:0] ival);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data <= CFG_W'(en);
        @(negedge clk);
        cfg_index <= CFG_INTERVAL;
        cfg_data <= ival;
        @(negedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
        config_writes += 2;
    endtask

    initial
    begin
        int ival;
        bit en;
        for (int i = 0; i < 2 * TITLE_MAX; i++)
            title_store[i] = '0;
        for (int p = 0; p < POOL_N; p++)
        begin
            pool_len[p] = (p == 0) ? 0 : $urandom_range(1, 28);
            for (int i = 0; i < pool_len[p]; i++)
                pool_chars[p][i] = rand_title_char();
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: pass-through from reset, empty title reads
        push_word(1'b0, 8'h00, '0);
        push_word(1'b0, 8'hFF, '1);
        push_word(1'b0, CHAR_QUOTE, '0);
        push_word(1'b1, 8'h00, '0);
        push_word(1'b1, 8'hFF, '1);

        // directed: one-word interval, zero length, new, same, NUL, cut, escaped
        set_config(1'b1, 16'd1);
        push_word(1'b0, 8'hAA, '0);
        push_word(1'b0, 8'h00, '0);
        push_word(1'b0, 8'h55, '0);
        add_text("StreamTitle='Hi';");
        send_block(2);
        push_word(1'b1, 8'h00, 10'd0);
        push_word(1'b1, 8'h00, 10'd1);
        push_word(1'b1, 8'h00, 10'd2);
        push_word(1'b0, 8'h11, '0);
        add_text("StreamTitle='Hi';");
        send_block(2);
        push_word(1'b0, 8'h22, '0);
        blk_q.push_back(CHAR_NUL);
        add_text("'Zz';");
        send_block(1);
        push_word(1'b0, 8'h33, '0);
        add_text("'abcdefghijklmnopqrstu");
        send_block(1);
        push_word(1'b0, 8'h44, '0);
        add_text("'it''s';");
        send_block(1);
        push_word(1'b1, 8'h00, 10'd2);
        push_word(1'b1, 8'h00, 10'd3);

        idle_ok = 1'b1;
        mix_reads = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            en = 1'b1;
            case (k)
                0: ival = $urandom_range(1, 8);
                1: ival = $urandom_range(9, 40);
                2:
                begin
                    en = 1'b0;
                    ival = $urandom_range(1, 65535);
                end
                3: ival = 1;
                4: ival = 65535;
                default: ival = $urandom_range(1, 20);
            endcase
            set_config(en, CFG_W'(ival));
            if (!en || ival == 65535)
                push_audio(80);
            else
                send_frames(ival, 70);
        end

        idle_ok = 1'b0;
        set_config(1'b1, 16'd4);
        send_frames(4, 40);

        while (pending_words.size() != 0 || word_held)
            @(negedge clk);
        for (int c = 0; c < 4000 && expected_results.size() != 0; c++)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end

        $display("Sent %0d words over %0d register writes; checked %0d results.",
                 stim_words, config_writes, results_checked);
        $display("Covered pass-through, short to 65535 intervals, cut blocks, %0d title changes.",
                 title_changes);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
